// ===== src/intensity_depth_downsample_2x2_defines.svh =====
// Assertion macros for the checker file.
`ifndef INTENSITY_DEPTH_DOWNSAMPLE_2X2_DEFINES_SVH
`define INTENSITY_DEPTH_DOWNSAMPLE_2X2_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IDDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define IDDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/idds_pkg.sv =====
`default_nettype none

package idds_pkg;

    localparam int CFG_W      = 12;
    localparam int ROW_W      = 11;
    localparam int MAX_HEIGHT = 2048;
    localparam int IDX_W      = 1;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;

    // floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT for x < 2**19
    localparam logic [17:0] RECIP3       = 18'd174763;
    localparam int          RECIP3_SHIFT = 19;

    typedef struct packed {
        logic [7:0]  pixel_intensity;
        logic [15:0] pixel_depth;
        logic        frame_start;
    } pixel_t;

    typedef struct packed {
        logic [7:0]  out_intensity;
        logic [15:0] out_depth;
        logic        end_of_row;
        logic        end_of_frame;
    } result_t;

    typedef struct packed {
        logic [1:0]  cnt;
        logic [16:0] dsum;
        logic [8:0]  isum;
    } pair_t;

    typedef struct packed {
        pair_t pair;
        logic  eor;
        logic  eof;
    } blk_t;

endpackage

`default_nettype wire

// ===== src/idds_line_store.sv =====
`default_nettype none

module idds_line_store #(
    parameter int DEPTH = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire idds_pkg::pair_t            wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output idds_pkg::pair_t                 rd_data
);

    idds_pkg::pair_t mem [DEPTH];
    idds_pkg::pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/idds_front.sv =====
`default_nettype none

module idds_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [idds_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [idds_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              accept,
    input  wire logic                              adv,
    input  wire idds_pkg::pixel_t                  pixel,
    output logic                                   wr_en,
    output logic                                   rd_en,
    output logic [$clog2(MAX_WIDTH/2)-1:0]         addr,
    output idds_pkg::pair_t                        wr_data,
    output logic                                   s1_valid,
    output idds_pkg::blk_t                         s1_blk
);

    localparam int CFG_W = idds_pkg::CFG_W;
    localparam int ROW_W = idds_pkg::ROW_W;
    localparam int WCAP  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4095;
    localparam int CW    = $clog2(WCAP);
    localparam int AW    = $clog2(MAX_WIDTH / 2);

    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic [CW-1:0]    column_count_reg;
    logic [CW-1:0]    column_count_next;
    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] row_count_next;
    idds_pkg::pair_t  pair_reg;
    logic             s1_valid_reg;
    idds_pkg::blk_t   s1_blk_reg;

    logic [CFG_W-1:0] wid;
    logic [CFG_W-1:0] hgt;
    logic [CW-1:0]    col;
    logic [ROW_W-1:0] row;
    logic             in_blk;
    logic [CFG_W:0]   col_inc;
    logic [CFG_W:0]   row_inc;
    logic             last_col;
    logic             last_row;
    logic             depth_ok;
    idds_pkg::pair_t  pair_sum;

    always_comb
    begin
        wid = (image_width_reg > CFG_W'(WCAP)) ? CFG_W'(WCAP) : image_width_reg;
        hgt = (image_height_reg > CFG_W'(idds_pkg::MAX_HEIGHT)) ?
              CFG_W'(idds_pkg::MAX_HEIGHT) : image_height_reg;
        col = pixel.frame_start ? '0 : column_count_reg;
        row = pixel.frame_start ? '0 : row_count_reg;

        in_blk = (CFG_W'(col) < {wid[CFG_W-1:1], 1'b0})
              && (CFG_W'(row) < {hgt[CFG_W-1:1], 1'b0});

        depth_ok      = pixel.pixel_depth != 16'd0;
        pair_sum.isum = pair_reg.isum + 9'(pixel.pixel_intensity);
        pair_sum.dsum = pair_reg.dsum + 17'(pixel.pixel_depth);
        pair_sum.cnt  = pair_reg.cnt + 2'(depth_ok);

        last_col = CFG_W'(col >> 1) == (wid >> 1) - CFG_W'(1);
        last_row = CFG_W'(row >> 1) == (hgt >> 1) - CFG_W'(1);

        col_inc = (CFG_W + 1)'(col) + (CFG_W + 1)'(1);
        row_inc = (CFG_W + 1)'(row) + (CFG_W + 1)'(1);
        if (col_inc >= (CFG_W + 1)'(wid))
        begin
            column_count_next = '0;
            row_count_next    = (row_inc >= (CFG_W + 1)'(hgt)) ? '0 : ROW_W'(row_inc);
        end
        else
        begin
            column_count_next = CW'(col_inc);
            row_count_next    = row;
        end

        wr_en   = accept && in_blk && col[0] && !row[0];
        rd_en   = accept && in_blk && col[0] && row[0];
        addr    = AW'(col >> 1);
        wr_data = pair_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= idds_pkg::IMAGE_WIDTH_RESET;
            image_height_reg <= idds_pkg::IMAGE_HEIGHT_RESET;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            pair_reg         <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    idds_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                    idds_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    default:                    image_width_reg  <= image_width_reg;
                endcase
            end
            if (accept)
            begin
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
                if (in_blk && !col[0])
                begin
                    pair_reg.isum <= 9'(pixel.pixel_intensity);
                    pair_reg.dsum <= 17'(pixel.pixel_depth);
                    pair_reg.cnt  <= 2'(depth_ok);
                end
            end
            if (adv)
            begin
                s1_valid_reg <= rd_en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_blk_reg.pair <= pair_sum;
            s1_blk_reg.eor  <= last_col;
            s1_blk_reg.eof  <= last_col && last_row;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_blk   = s1_blk_reg;

endmodule

`default_nettype wire

// ===== src/idds_mean.sv =====
`default_nettype none

module idds_mean (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               s1_valid,
    input  wire idds_pkg::blk_t     s1_blk,
    input  wire idds_pkg::pair_t    store_data,
    output logic                    result_valid,
    output idds_pkg::result_t       result
);

    logic               s2_valid_reg;
    logic [9:0]         ti_reg;
    logic [17:0]        td_reg;
    logic [2:0]         tc_reg;
    logic               eor_reg;
    logic               eof_reg;
    logic               result_valid_reg;
    idds_pkg::result_t  result_reg;

    logic [35:0]        prod3;
    logic [15:0]        mean;

    always_comb
    begin
        prod3 = 36'(td_reg) * 36'(idds_pkg::RECIP3);
        unique case (tc_reg)
            3'd1:    mean = td_reg[15:0];
            3'd2:    mean = td_reg[16:1];
            3'd3:    mean = prod3[idds_pkg::RECIP3_SHIFT +: 16];
            3'd4:    mean = td_reg[17:2];
            default: mean = 16'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg     <= s1_valid;
            result_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ti_reg  <= 10'(s1_blk.pair.isum) + 10'(store_data.isum);
            td_reg  <= 18'(s1_blk.pair.dsum) + 18'(store_data.dsum);
            tc_reg  <= 3'(s1_blk.pair.cnt) + 3'(store_data.cnt);
            eor_reg <= s1_blk.eor;
            eof_reg <= s1_blk.eof;

            result_reg.out_intensity <= ti_reg[9:2];
            result_reg.out_depth     <= mean;
            result_reg.end_of_row    <= eor_reg;
            result_reg.end_of_frame  <= eof_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== src/intensity_depth_downsample_2x2.sv =====
// The block of a closing pixel goes through s1 (with the line store read), the block sums
// and the result register. Throughput: one pixel per cycle, with at most one line store
// read or write per pixel; the pipeline holds whole while a result stalls.
// Reset: rst_n is asynchronous and clears counters, pair sums and pipeline valids and
// loads 640x480; the line store is not cleared and is read only after it is written.
`default_nettype none

module intensity_depth_downsample_2x2 #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pixel_valid,
    output logic                              pixel_stall,
    input  wire idds_pkg::pixel_t             pixel,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output idds_pkg::result_t                 result,
    input  wire logic                         cfg_wr_en,
    input  wire logic [idds_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [idds_pkg::CFG_W-1:0]   cfg_data
);

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = $clog2(DEPTH);

    logic             adv;
    logic             accept;
    logic             wr_en;
    logic             rd_en;
    logic [AW-1:0]    addr;
    idds_pkg::pair_t  wr_data;
    idds_pkg::pair_t  store_data;
    logic             s1_valid;
    idds_pkg::blk_t   s1_blk;

    assign adv         = !(result_valid && result_stall);
    assign pixel_stall = !adv;
    assign accept      = pixel_valid && adv;

    idds_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .adv       (adv),
        .pixel     (pixel),
        .wr_en     (wr_en),
        .rd_en     (rd_en),
        .addr      (addr),
        .wr_data   (wr_data),
        .s1_valid  (s1_valid),
        .s1_blk    (s1_blk)
    );

    idds_line_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (store_data)
    );

    idds_mean u_mean (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .s1_valid     (s1_valid),
        .s1_blk       (s1_blk),
        .store_data   (store_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== src/idds_checker.sv =====
`default_nettype none
`include "intensity_depth_downsample_2x2_defines.svh"

module idds_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               pixel_valid,
    input wire logic               pixel_stall,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire idds_pkg::result_t  result
);

    `IDDS_ASSERT_NOW(a_eof_on_eor, result_valid && result.end_of_frame, result.end_of_row, "end_of_frame without end_of_row")

    `IDDS_ASSERT_NOW(a_stall_back, result_valid && result_stall, pixel_stall, "pixel taken while result is held")

    `IDDS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

    `IDDS_ASSERT_NOW(a_free_when_idle, pixel_valid && !result_valid, !pixel_stall, "pixel stalled with no result waiting")

endmodule

bind intensity_depth_downsample_2x2 idds_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int BIN_MAX_WIDTH  = 2048;
    localparam int STORE_DEPTH    = BIN_MAX_WIDTH / 2;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]  cnt;
        logic [16:0] dsum;
        logic [8:0]  isum;
    } pair_sum_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       pixel_valid = 1'b0;
    logic                       pixel_stall;
    idds_pkg::pixel_t           pixel = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    idds_pkg::result_t          result;
    logic                       cfg_wr_en = 1'b0;
    logic [idds_pkg::IDX_W-1:0] cfg_index = idds_pkg::REG_IMAGE_WIDTH;
    logic [idds_pkg::CFG_W-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatch_count = 0;

    // binning predictor state
    logic [idds_pkg::CFG_W-1:0] img_width = idds_pkg::IMAGE_WIDTH_RESET;
    logic [idds_pkg::CFG_W-1:0] img_height = idds_pkg::IMAGE_HEIGHT_RESET;
    int unsigned                col_pos = 0;
    int unsigned                row_pos = 0;
    logic [8:0]                 left_isum = '0;
    logic [16:0]                left_dsum = '0;
    logic [1:0]                 left_cnt = '0;
    pair_sum_t                  line_pairs [0:STORE_DEPTH-1];
    idds_pkg::result_t          pending_blocks [$];

    intensity_depth_downsample_2x2 #(
        .MAX_WIDTH(BIN_MAX_WIDTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    task automatic bin_pixel(input idds_pkg::pixel_t p);
        int unsigned       wid, hgt, ow, oh, c, r, idx, tot_i, tot_d, tot_c;
        logic [8:0]        isum;
        logic [16:0]       dsum;
        logic [1:0]        cnt;
        idds_pkg::result_t res;
        wid = (img_width > BIN_MAX_WIDTH) ? BIN_MAX_WIDTH : img_width;
        hgt = (img_height > idds_pkg::MAX_HEIGHT) ? idds_pkg::MAX_HEIGHT : img_height;
        ow = wid / 2;
        oh = hgt / 2;
        if (p.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        if (c < 2 * ow && r < 2 * oh)
        begin
            if (c % 2 == 0)
            begin
                left_isum = 9'(p.pixel_intensity);
                left_dsum = 17'(p.pixel_depth);
                left_cnt  = 2'(p.pixel_depth != 16'd0);
            end
            else
            begin
                isum = left_isum + 9'(p.pixel_intensity);
                dsum = left_dsum + 17'(p.pixel_depth);
                cnt  = left_cnt + 2'(p.pixel_depth != 16'd0);
                idx  = (c / 2) % STORE_DEPTH;
                if (r % 2 == 0)
                    line_pairs[idx] = '{cnt, dsum, isum};
                else
                begin
                    tot_i = 32'(isum) + 32'(line_pairs[idx].isum);
                    tot_d = 32'(dsum) + 32'(line_pairs[idx].dsum);
                    tot_c = 32'(cnt) + 32'(line_pairs[idx].cnt);
                    res.out_intensity = 8'(tot_i / 4);
                    case (tot_c)
                        1: res.out_depth = 16'(tot_d);
                        2: res.out_depth = 16'(tot_d / 2);
                        3: res.out_depth = 16'(tot_d / 3);
                        4: res.out_depth = 16'(tot_d / 4);
                        default: res.out_depth = '0;
                    endcase
                    res.end_of_row   = (c / 2 == ow - 1);
                    res.end_of_frame = res.end_of_row && (r / 2 == oh - 1);
                    pending_blocks.push_back(res);
                end
            end
        end
        if (c + 1 >= wid)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= hgt) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    function automatic idds_pkg::pixel_t mk_pixel(input int inten, input int depth,
                                                  input bit fs);
        idds_pkg::pixel_t p;
        p.pixel_intensity = inten[7:0];
        p.pixel_depth     = depth[15:0];
        p.frame_start     = fs;
        return p;
    endfunction

    function automatic idds_pkg::pixel_t rand_pixel();
        int sel_i, sel_d, inten, depth;
        sel_i = $urandom_range(9);
        sel_d = $urandom_range(9);
        inten = (sel_i == 0) ? 255 : (sel_i == 1) ? 0 : $urandom_range(255);
        depth = (sel_d < 3) ? 0 : (sel_d == 3) ? 65535 : $urandom_range(65535);
        return mk_pixel(inten, depth, 1'b0);
    endfunction

    task automatic push_pixel(input idds_pkg::pixel_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= p;
        do
            @(posedge clk);
        while (pixel_stall !== 1'b0);
        bin_pixel(p);
    endtask

    task automatic send_frame(input bit fs_first, input int count, input int noise_pct);
        idds_pkg::pixel_t p;
        for (int i = 0; i < count; i++)
        begin
            p = rand_pixel();
            p.frame_start = (i == 0) ? fs_first : ($urandom_range(99) < noise_pct);
            push_pixel(p);
        end
    endtask

    task automatic settle();
        pixel_valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic config_size(input int w, input int h);
        cfg_wr_en <= 1'b1;
        cfg_index <= idds_pkg::REG_IMAGE_WIDTH;
        cfg_data  <= w[idds_pkg::CFG_W-1:0];
        @(posedge clk);
        img_width = w[idds_pkg::CFG_W-1:0];
        cfg_index <= idds_pkg::REG_IMAGE_HEIGHT;
        cfg_data  <= h[idds_pkg::CFG_W-1:0];
        @(posedge clk);
        img_height = h[idds_pkg::CFG_W-1:0];
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_directed_blocks();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settle();
        config_size(4, 2);
        push_pixel(mk_pixel(255, 65535, 1'b1));
        push_pixel(mk_pixel(255, 65535, 1'b0));
        push_pixel(mk_pixel(0, 0, 1'b0));
        push_pixel(mk_pixel(0, 7, 1'b0));
        push_pixel(mk_pixel(255, 65535, 1'b0));
        push_pixel(mk_pixel(255, 65535, 1'b0));
        push_pixel(mk_pixel(1, 5, 1'b0));
        push_pixel(mk_pixel(3, 9, 1'b0));
        // all-zero block; trailing column and row carry extremes that must be dropped
        settle();
        config_size(3, 3);
        for (int i = 0; i < 9; i++)
        begin
            if (i % 3 == 2 || i / 3 == 2)
                push_pixel(mk_pixel(255, 65535, i == 0));
            else
                push_pixel(mk_pixel(0, 0, i == 0));
        end
    endtask

    task automatic test_tiny_images();
        int sizes [5][2] = '{'{0, 0}, '{1, 4}, '{6, 1}, '{4, 0}, '{0, 3}};
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        foreach (sizes[k])
        begin
            settle();
            config_size(sizes[k][0], sizes[k][1]);
            send_frame(1'b1, 8, 0);
        end
    endtask

    task automatic test_size_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settle();
        config_size(2048, 2);
        send_frame(1'b1, 32, 0);
        settle();
        config_size(2, 2048);
        send_frame(1'b1, 32, 0);
        settle();
        config_size(4095, 4095);
        send_frame(1'b1, 32, 0);
    endtask

    task automatic test_height_cut();
        send_idle_pct  = 67;
        recv_stall_pct = 0;
        settle();
        config_size(4, 12);
        send_frame(1'b1, 38, 0);
        // rows past the new height are skipped until the row counter wraps
        settle();
        config_size(4, 4);
        send_frame(1'b0, 18, 0);
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settle();
        config_size(8, 8);
        hold_token <= hold_token + 1;
        send_frame(1'b1, 64, 0);
    endtask

    task automatic test_random_frames(input int idle_pct, input int stall_pct, input int budget);
        int sent, w, h, cnt;
        bit fs_first, broken;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent   = 0;
        broken = 1'b1;
        w = 2;
        h = 2;
        while (sent < budget)
        begin
            if (broken || $urandom_range(99) < 70)
            begin
                w = ($urandom_range(19) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 2);
                h = $urandom_range(8, 2);
                settle();
                config_size(w, h);
                fs_first = 1'b1;
            end
            else
                fs_first = $urandom_range(1);
            cnt = w * h;
            broken = ($urandom_range(9) == 0);
            if (broken)
                cnt = $urandom_range(cnt, 1);
            send_frame(fs_first, cnt, 3);
            sent += cnt;
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen    <= hold_token;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        idds_pkg::result_t want;
        if (rst_n && result_valid === 1'b1 && !result_stall)
        begin
            if (pending_blocks.size() == 0)
            begin
                $error("unexpected transaction: %p", result);
                mismatch_count++;
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (result.out_intensity !== want.out_intensity)
                begin
                    $error("out_intensity expected %0d actual %0d",
                           want.out_intensity, result.out_intensity);
                    mismatch_count++;
                end
                if (result.out_depth !== want.out_depth)
                begin
                    $error("out_depth expected %0d actual %0d", want.out_depth, result.out_depth);
                    mismatch_count++;
                end
                if (result.end_of_row !== want.end_of_row)
                begin
                    $error("end_of_row expected %0d actual %0d",
                           want.end_of_row, result.end_of_row);
                    mismatch_count++;
                end
                if (result.end_of_frame !== want.end_of_frame)
                begin
                    $error("end_of_frame expected %0d actual %0d",
                           want.end_of_frame, result.end_of_frame);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pixel_valid && pixel_stall === 1'b0) || (result_valid === 1'b1 && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_blocks();
        test_tiny_images();
        test_size_extremes();
        test_height_cut();
        test_backpressure();
        test_random_frames(0, 0, 50);
        test_random_frames(67, 0, 50);
        test_random_frames(0, 67, 50);
        test_random_frames(9, 9, 50);
        settle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
